/* hw/rtl/throttle_curve_interpolator_core_assert.svh */
// Assertion macros for the throttle curve core.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef THROTTLE_CURVE_INTERPOLATOR_CORE_ASSERT_SVH
`define THROTTLE_CURVE_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TCI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("throttle curve assertion failed");
`define TCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("throttle curve assertion failed");
`else
`define TCI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TCI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/tci_pkg.sv */
// Shared constants, register indexes and segment selection for the throttle curve core.
// No dependencies.
`default_nettype none

package tci_pkg;

  localparam int FIELD_W      = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SAT_EXP      = 40;
  localparam int QUO_BITS     = SAT_EXP + 1;
  localparam int DEF_DEN_W    = 18;
  localparam int DEF_NUM_W    = DEF_DEN_W + SAT_EXP + 3;

  localparam logic [CFG_IDX_W-1:0] REG_KNOT_X1   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_X2   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_X3   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_Y1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_Y2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_Y3   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_BLEND = 3'd6;

  localparam logic [FIELD_W-1:0] RST_KNOT_X1 = 17'd16384;
  localparam logic [FIELD_W-1:0] RST_KNOT_X2 = 17'd32768;
  localparam logic [FIELD_W-1:0] RST_KNOT_X3 = 17'd49152;

  // linear segment codes
  localparam logic [2:0] SEG_FIRST  = 3'd0;
  localparam logic [2:0] SEG_SECOND = 3'd1;
  localparam logic [2:0] SEG_THIRD  = 3'd2;
  localparam logic [2:0] SEG_LAST   = 3'd3;
  localparam logic [2:0] SEG_KNOT   = 3'd4;

  function automatic logic [2:0] seg_sel(input logic [FIELD_W-1:0] t,
                                         input logic [FIELD_W-1:0] x1,
                                         input logic [FIELD_W-1:0] x2,
                                         input logic [FIELD_W-1:0] x3);
    logic [2:0] code;
    if (t < x1) begin
      code = SEG_FIRST;
    end else if (t > x3) begin
      code = SEG_LAST;
    end else if (t > x2) begin
      code = SEG_THIRD;
    end else if (t > x1) begin
      code = SEG_SECOND;
    end else begin
      code = SEG_KNOT;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tci_div.sv */
// Pipelined signed divider, one quotient bit per stage, saturating to +/-2^(QB-1).
// Division by zero gives the numerator's sign at full scale. Uses tci_pkg.
`default_nettype none

module tci_div #(
  parameter int NUM_W = tci_pkg::DEF_NUM_W,
  parameter int DEN_W = tci_pkg::DEF_DEN_W,
  parameter int QB    = tci_pkg::QUO_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic signed [DEN_W-1:0] den,
  output logic signed [QB:0]           quo
);

  localparam logic [QB-1:0] SAT = {1'b1, {(QB-1){1'b0}}};

  logic [NUM_W-1:0] nmag_a;
  logic [DEN_W-1:0] dmag_a;
  logic             neg_a, zero_a;

  logic [NUM_W-1:0] rem  [0:QB];
  logic [DEN_W-1:0] dm   [0:QB];
  logic [QB-1:0]    qv   [0:QB];
  logic             neg  [0:QB];
  logic             zero [0:QB];
  logic             ovf  [0:QB];

  logic [QB-1:0]    mag;

  // take magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      nmag_a <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag_a <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      neg_a  <= num[NUM_W-1] ^ den[DEN_W-1];
      zero_a <= (num == '0);
    end
  end

  // flag quotients that cannot fit the bit stages
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= nmag_a;
      dm[0]   <= dmag_a;
      qv[0]   <= '0;
      neg[0]  <= neg_a;
      zero[0] <= zero_a;
      ovf[0]  <= (NUM_W'(dmag_a) << QB) <= nmag_a;
    end
  end

  for (genvar b = 0; b < QB; b++) begin : g_bit
    logic [NUM_W-1:0] trial;
    logic             ge;
    assign trial = NUM_W'(dm[b]) << (QB - 1 - b);
    assign ge    = rem[b] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[b+1]  <= ge ? rem[b] - trial : rem[b];
        dm[b+1]   <= dm[b];
        qv[b+1]   <= {qv[b][QB-2:0], ge};
        neg[b+1]  <= neg[b];
        zero[b+1] <= zero[b];
        ovf[b+1]  <= ovf[b];
      end
    end
  end

  assign mag = (ovf[QB] || (qv[QB] > SAT)) ? SAT : qv[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero[QB]) begin
        quo <= '0;
      end else if (neg[QB]) begin
        quo <= -$signed({1'b0, mag});
      end else begin
        quo <= $signed({1'b0, mag});
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/throttle_curve_interpolator_core.sv */
// Top level of the five-knot throttle curve: piecewise-linear and Neville polynomial
// values blended and clamped. Depends on tci_pkg, tci_div and the assertion header.
//
// Usage:
//  - Input channel (in_valid / in_stall / throttle) and output channel
//    (out_valid / out_stall / shaped_throttle); a transfer happens on a rising
//    edge with valid high and stall low. All values are unsigned Q1.16.
//  - Knots and blend weight must be written through cfg_we / cfg_idx / cfg_wdata
//    only while no item is in flight, which the block leaves unchecked; it reads them live.
//  - Throughput: one item per cycle while the skid register is empty. Four
//    Neville levels each run a multiply stage, a subtract stage and a
//    bit-per-stage divider of QUO_BITS+3 stages; the linear segment runs its
//    own divider beside the last level, then five blend/clamp stages follow.
//  - Reset clears all valid bits and the skid register and loads the default
//    knots (0.25, 0.5, 0.75 on the diagonal) with zero blend.
//  - When the receiver stalls, the last result moves into a skid register and
//    the whole pipeline holds; in_stall is that register's valid, so it rises
//    in the cycle after the output stalls and no item is lost or repeated.
`default_nettype none
`include "throttle_curve_interpolator_core_assert.svh"

module throttle_curve_interpolator_core #(
  parameter int FRAC_BITS = tci_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [tci_pkg::FIELD_W-1:0]       throttle,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [tci_pkg::FIELD_W-1:0]            shaped_throttle,
  input  wire logic                              cfg_we,
  input  wire logic [tci_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [tci_pkg::FIELD_W-1:0]       cfg_wdata
);

  localparam int FLD  = tci_pkg::FIELD_W;
  localparam int MAXB = (FRAC_BITS + 1 > FLD) ? FRAC_BITS + 1 : FLD;
  localparam int XW   = MAXB + 1;                 // signed knot differences
  localparam int QB   = tci_pkg::QUO_BITS;
  localparam int FW   = QB + 1;                   // saturated Neville terms
  localparam int PW   = XW + FW;
  localparam int NW   = PW + 1;
  localparam int LW   = FW + 1;
  localparam int BW   = FLD + 1;
  localparam int PBW  = LW + BW;
  localparam int RW   = PBW + 1;
  localparam int LL   = QB + 5;                   // stages per level
  localparam int TLEN = 4 * LL;
  localparam int TOT  = TLEN + 5;

  localparam logic signed [XW-1:0]  ONE_X = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [FW-1:0]  ONE_F = {{(FW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [RW-1:0]  ONE_R = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [PBW-1:0] BIAS  = ({{(PBW-1){1'b0}}, 1'b1} << FRAC_BITS) - 1;
  localparam logic signed [LW-1:0]  SATP  = {{(LW-1){1'b0}}, 1'b1} << tci_pkg::SAT_EXP;
  localparam logic signed [LW-1:0]  SATN  = -SATP;
  localparam logic [FLD-1:0] OUT_MAX = (FRAC_BITS > FLD - 1) ? {FLD{1'b1}} : FLD'(ONE_X);

  // configuration registers
  logic [FLD-1:0] knot_x1, knot_x2, knot_x3;
  logic [FLD-1:0] knot_y1, knot_y2, knot_y3;
  logic [FLD-1:0] linear_blend;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_x1      <= tci_pkg::RST_KNOT_X1;
      knot_x2      <= tci_pkg::RST_KNOT_X2;
      knot_x3      <= tci_pkg::RST_KNOT_X3;
      knot_y1      <= tci_pkg::RST_KNOT_X1;
      knot_y2      <= tci_pkg::RST_KNOT_X2;
      knot_y3      <= tci_pkg::RST_KNOT_X3;
      linear_blend <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        tci_pkg::REG_KNOT_X1:   knot_x1      <= cfg_wdata;
        tci_pkg::REG_KNOT_X2:   knot_x2      <= cfg_wdata;
        tci_pkg::REG_KNOT_X3:   knot_x3      <= cfg_wdata;
        tci_pkg::REG_KNOT_Y1:   knot_y1      <= cfg_wdata;
        tci_pkg::REG_KNOT_Y2:   knot_y2      <= cfg_wdata;
        tci_pkg::REG_KNOT_Y3:   knot_y3      <= cfg_wdata;
        tci_pkg::REG_LIN_BLEND: linear_blend <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // knots widened to signed working formats; end knots are (0,0) and (1,1)
  logic signed [XW-1:0] kx [0:4];
  logic signed [XW-1:0] ky [0:4];
  logic signed [FW-1:0] ky_f [0:4];

  assign kx[0] = '0;
  assign kx[1] = signed'({{(XW-FLD){1'b0}}, knot_x1});
  assign kx[2] = signed'({{(XW-FLD){1'b0}}, knot_x2});
  assign kx[3] = signed'({{(XW-FLD){1'b0}}, knot_x3});
  assign kx[4] = ONE_X;
  assign ky[0] = '0;
  assign ky[1] = signed'({{(XW-FLD){1'b0}}, knot_y1});
  assign ky[2] = signed'({{(XW-FLD){1'b0}}, knot_y2});
  assign ky[3] = signed'({{(XW-FLD){1'b0}}, knot_y3});
  assign ky[4] = ONE_X;

  for (genvar k = 0; k < 5; k++) begin : g_kyf
    assign ky_f[k] = FW'(ky[k]);
  end

  // pipeline control: the whole pipe advances unless the skid register is full
  logic           adv;
  logic [TOT:0]   vld;
  logic [FLD-1:0] t_pipe [0:TLEN];
  logic           skid_valid;
  logic [FLD-1:0] skid_data;
  logic [FLD-1:0] res_q;

  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOT-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_pipe[0] <= throttle;
      for (int s = 1; s <= TLEN; s++) begin
        t_pipe[s] <= t_pipe[s-1];
      end
    end
  end

  // Neville levels: level lv replaces terms lv..4 from the terms of level lv-1
  logic signed [FW-1:0] f_out [0:4][0:4];

  for (genvar k = 0; k < 5; k++) begin : g_f0
    assign f_out[0][k] = ky_f[k];
  end

  for (genvar lv = 1; lv <= 4; lv++) begin : g_lvl
    logic signed [XW-1:0] t_at;
    assign t_at = signed'({{(XW-FLD){1'b0}}, t_pipe[(lv-1)*LL]});

    for (genvar i = 0; i < 5; i++) begin : g_lane
      if (i >= lv) begin : g_act
        logic signed [XW-1:0] da, db;
        logic signed [PW-1:0] pa, pb;
        logic signed [NW-1:0] num;
        logic signed [XW-1:0] den;

        assign da = t_at - kx[i-lv];
        assign db = t_at - kx[i];

        always_ff @(posedge clk) begin
          if (adv) begin
            pa  <= da * f_out[lv-1][i];
            pb  <= db * f_out[lv-1][i-1];
            num <= NW'(pa) - NW'(pb);
            den <= kx[i] - kx[i-lv];
          end
        end

        tci_div #(.NUM_W(NW), .DEN_W(XW), .QB(QB)) u_div (
          .clk (clk),
          .en  (adv),
          .num (num),
          .den (den),
          .quo (f_out[lv][i])
        );
      end else begin : g_idle
        assign f_out[lv][i] = '0;
      end
    end
  end

  // linear segment, run beside the last Neville level
  logic [2:0]             sel_m;
  logic signed [XW-1:0]   xa, ya, xb, yb, t_lin;
  logic signed [2*XW-1:0] p_lin;
  logic signed [XW-1:0]   dx_lin;
  logic signed [NW-1:0]   lin_num;
  logic signed [XW-1:0]   lin_den;
  logic signed [FW-1:0]   lin_q;

  assign t_lin = signed'({{(XW-FLD){1'b0}}, t_pipe[3*LL]});
  assign sel_m = tci_pkg::seg_sel(t_pipe[3*LL], knot_x1, knot_x2, knot_x3);

  always_comb begin
    case (sel_m)
      tci_pkg::SEG_FIRST: begin
        xa = kx[0]; ya = ky[0]; xb = kx[1]; yb = ky[1];
      end
      tci_pkg::SEG_LAST: begin
        xa = kx[3]; ya = ky[3]; xb = kx[4]; yb = ky[4];
      end
      tci_pkg::SEG_THIRD: begin
        xa = kx[2]; ya = ky[2]; xb = kx[3]; yb = ky[3];
      end
      default: begin
        xa = kx[1]; ya = ky[1]; xb = kx[2]; yb = ky[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lin   <= (yb - ya) * (t_lin - xa);
      dx_lin  <= xb - xa;
      lin_num <= NW'(p_lin);
      lin_den <= dx_lin;
    end
  end

  tci_div #(.NUM_W(NW), .DEN_W(XW), .QB(QB)) u_lin_div (
    .clk (clk),
    .en  (adv),
    .num (lin_num),
    .den (lin_den),
    .quo (lin_q)
  );

  // blend stages: lin, difference, product, scale, clamp
  logic [2:0]            sel_f;
  logic signed [XW-1:0]  ya_f;
  logic signed [LW-1:0]  lin_sum;
  logic signed [FW-1:0]  lin_val;
  logic signed [FW-1:0]  lin_r, poly1, poly2, poly3, poly4;
  logic signed [LW-1:0]  diff_r;
  logic signed [PBW-1:0] prod_r, scaled_r;
  logic signed [RW-1:0]  res_w;

  assign sel_f = tci_pkg::seg_sel(t_pipe[TLEN], knot_x1, knot_x2, knot_x3);

  always_comb begin
    case (sel_f)
      tci_pkg::SEG_FIRST: ya_f = ky[0];
      tci_pkg::SEG_LAST:  ya_f = ky[3];
      tci_pkg::SEG_THIRD: ya_f = ky[2];
      default:            ya_f = ky[1];
    endcase
    lin_sum = LW'(ya_f) + LW'(lin_q);
    if (sel_f == tci_pkg::SEG_KNOT) begin
      lin_val = ky_f[1];
    end else if (lin_sum > SATP) begin
      lin_val = FW'(SATP);
    end else if (lin_sum < SATN) begin
      lin_val = FW'(SATN);
    end else begin
      lin_val = FW'(lin_sum);
    end
  end

  always_comb begin
    res_w = RW'(poly4) - RW'(scaled_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin_r    <= lin_val;
      poly1    <= f_out[4][4];
      diff_r   <= LW'(poly1) - LW'(lin_r);
      poly2    <= poly1;
      prod_r   <= diff_r * $signed({1'b0, linear_blend});
      poly3    <= poly2;
      // truncate toward zero: bias negative products before the shift
      scaled_r <= $signed(prod_r + (prod_r[PBW-1] ? BIAS : '0)) >>> FRAC_BITS;
      poly4    <= poly3;
      if (res_w > ONE_R) begin
        res_q <= FLD'(ONE_R);
      end else if (res_w < 0) begin
        res_q <= '0;
      end else begin
        res_q <= res_w[FLD-1:0];
      end
    end
  end

  // skid register: hold the last result while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[TOT] && out_stall) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_data <= res_q;
    end
  end

  assign out_valid       = skid_valid || vld[TOT];
  assign shaped_throttle = skid_valid ? skid_data : res_q;

  `TCI_ASSERT_NEXT(a_skid_fill, clk, rst, !skid_valid && vld[TOT] && out_stall, skid_valid)
  `TCI_ASSERT_NEXT(a_skid_pass, clk, rst, !skid_valid && vld[TOT] && !out_stall, !skid_valid)
  `TCI_ASSERT_NEXT(a_pipe_hold, clk, rst, skid_valid, $stable(vld))
  `TCI_ASSERT_IMPL(a_out_range, clk, rst, out_valid, shaped_throttle <= OUT_MAX)

endmodule

`default_nettype wire
